[rtl/core/sxf_pkg.sv]
// constants and types shared by the stx/etx framer and deframer core
// no dependencies
`default_nettype none

package sxf_pkg;

	// framing bytes and length rules
	localparam logic [7:0] STX_BYTE      = 8'h02;
	localparam logic [7:0] ETX_BYTE      = 8'h03;
	localparam logic [7:0] LEN_OVERHEAD  = 8'd4;
	localparam logic [7:0] MIN_RX_LENGTH = 8'd5;

	// deepest run of results one item can cause
	localparam int unsigned MAX_RESULTS = 5;
	localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);

	// input selector
	typedef enum logic {
		OP_TX_PAYLOAD = 1'b0,
		OP_RX_LINE    = 1'b1
	} op_t;

	// result kind
	typedef enum logic [1:0] {
		KIND_TX_BYTE    = 2'd0,
		KIND_RX_PAYLOAD = 2'd1,
		KIND_RX_END     = 2'd2
	} kind_t;

	// deframer phase; the spare code hunts like RX_HUNT
	typedef enum logic [1:0] {
		RX_HUNT   = 2'd0,
		RX_LENGTH = 2'd1,
		RX_BODY   = 2'd2,
		RX_SPARE  = 2'd3
	} rx_phase_t;

endpackage

`default_nettype wire

[rtl/core/stx_etx_xor_framer_deframer_core.sv]
// stx/etx framer and deframer core with length byte and xor checksum
// depends on sxf_pkg
`default_nettype none

// An item is taken into an input register, worked through in one pass of
// logic, and its results (none to five) are loaded into a burst register
// that drives the master side one result per cycle while m_tready is high;
// an item with one result or none moves at one item per cycle unless the
// master side stalls; one with more results holds that side until its
// last is taken, as there is one result port. The next item is taken
// while the last result of the previous one still waits. Transmit items
// (tuser 0) carry a payload byte in tdata[7:0], the frame's payload count in
// tdata[15:8] (read with the first byte) and the final-byte mark on tlast;
// the frame goes out as STX, length, payload (toggle bit ORed into the first
// byte), ETX and the xor checksum. Receive items (tuser 1) carry one line
// byte; payload bytes come out with kind 1 and the frame end with kind 2 and
// its checksum and short-length flags. tlast marks the final result of the
// run caused by one item.
module stx_etx_xor_framer_deframer_core
	import sxf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] payload_count
	input  wire logic        s_tuser,   // [0] op
	input  wire logic        s_tlast,   // last_payload
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] checksum_ok, [9] bad_length
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);

	// input register
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;
	logic [7:0] count_s1;
	logic       lastp_s1;

	// framer and deframer state
	logic       toggle_q;
	logic       tx_started_q;
	logic [7:0] tx_chk_q;
	rx_phase_t  rx_phase_q;
	logic [7:0] rx_len_q;
	logic [7:0] rx_idx_q;
	logic [7:0] rx_chk_q;

	// burst register
	logic                 valid_s2;
	logic [7:0]           bytes_s2 [MAX_RESULTS];
	logic [RES_IDX_W-1:0] last_idx_s2;
	logic [RES_IDX_W-1:0] idx_q;
	kind_t                kind_s2;
	logic                 ok_s2;
	logic                 bad_s2;

	// next state and burst from the single pass
	logic                 toggle_d;
	logic                 tx_started_d;
	logic [7:0]           tx_chk_d;
	rx_phase_t            rx_phase_d;
	logic [7:0]           rx_len_d;
	logic [7:0]           rx_idx_d;
	logic [7:0]           rx_chk_d;
	logic [7:0]           bytes_d [MAX_RESULTS];
	logic [RES_IDX_W:0]   n_d;
	kind_t                kind_d;
	logic                 ok_d;
	logic                 bad_d;

	logic s2_done;
	logic advance;

	// handshake
	assign s2_done  = valid_s2 && m_tready && (idx_q == last_idx_s2);
	assign advance  = valid_s1 && (!valid_s2 || s2_done);
	assign s_tready = !valid_s1 || advance;

	// single pass over the held item
	always_comb begin
		logic [7:0] len_tx;
		logic [7:0] b_tx;
		logic [7:0] chk_tx;
		logic [8:0] idx_p2;
		toggle_d     = toggle_q;
		tx_started_d = tx_started_q;
		tx_chk_d     = tx_chk_q;
		rx_phase_d   = rx_phase_q;
		rx_len_d     = rx_len_q;
		rx_idx_d     = rx_idx_q;
		rx_chk_d     = rx_chk_q;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			bytes_d[i] = 8'h00;
		end
		n_d    = '0;
		kind_d = KIND_TX_BYTE;
		ok_d   = 1'b0;
		bad_d  = 1'b0;
		len_tx = count_s1 + LEN_OVERHEAD;
		b_tx   = tx_started_q ? byte_s1 : (byte_s1 | {7'd0, toggle_q});
		chk_tx = (tx_started_q ? tx_chk_q : len_tx) ^ b_tx;
		idx_p2 = {1'b0, rx_idx_q} + 9'd2;

		if (op_s1 == OP_TX_PAYLOAD) begin
			// frame header only on the first byte
			tx_chk_d     = chk_tx;
			tx_started_d = 1'b1;
			if (!tx_started_q) begin
				bytes_d[0] = STX_BYTE;
				bytes_d[1] = len_tx;
				bytes_d[2] = b_tx;
				bytes_d[3] = ETX_BYTE;
				bytes_d[4] = chk_tx;
				n_d        = lastp_s1 ? (RES_IDX_W+1)'(5) : (RES_IDX_W+1)'(3);
			end else begin
				bytes_d[0] = b_tx;
				bytes_d[1] = ETX_BYTE;
				bytes_d[2] = chk_tx;
				n_d        = lastp_s1 ? (RES_IDX_W+1)'(3) : (RES_IDX_W+1)'(1);
			end
			// frame close
			if (lastp_s1) begin
				tx_started_d = 1'b0;
				toggle_d     = !toggle_q;
			end
		end else begin
			case (rx_phase_q)
				RX_LENGTH: begin
					rx_len_d = byte_s1;
					rx_chk_d = byte_s1;
					rx_idx_d = 8'd2;
					if (byte_s1 < MIN_RX_LENGTH) begin
						kind_d     = KIND_RX_END;
						bad_d      = 1'b1;
						n_d        = (RES_IDX_W+1)'(1);
						rx_phase_d = RX_HUNT;
					end else begin
						rx_phase_d = RX_BODY;
					end
				end
				RX_BODY: begin
					if (idx_p2 < {1'b0, rx_len_q}) begin
						rx_chk_d   = rx_chk_q ^ byte_s1;
						kind_d     = KIND_RX_PAYLOAD;
						bytes_d[0] = byte_s1;
						n_d        = (RES_IDX_W+1)'(1);
						rx_idx_d   = rx_idx_q + 8'd1;
					end else if (idx_p2 == {1'b0, rx_len_q}) begin
						// etx position, skipped
						rx_idx_d = rx_idx_q + 8'd1;
					end else begin
						kind_d     = KIND_RX_END;
						ok_d       = (rx_chk_q == byte_s1);
						n_d        = (RES_IDX_W+1)'(1);
						rx_phase_d = RX_HUNT;
					end
				end
				default: begin
					rx_phase_d = (byte_s1 == STX_BYTE) ? RX_LENGTH : RX_HUNT;
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= op_t'(s_tuser);
			byte_s1  <= s_tdata[7:0];
			count_s1 <= s_tdata[15:8];
			lastp_s1 <= s_tlast;
		end
	end

	// state update as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q     <= 1'b0;
			tx_started_q <= 1'b0;
			tx_chk_q     <= 8'h00;
			rx_phase_q   <= RX_HUNT;
			rx_len_q     <= 8'h00;
			rx_idx_q     <= 8'h00;
			rx_chk_q     <= 8'h00;
		end else if (advance) begin
			toggle_q     <= toggle_d;
			tx_started_q <= tx_started_d;
			tx_chk_q     <= tx_chk_d;
			rx_phase_q   <= rx_phase_d;
			rx_len_q     <= rx_len_d;
			rx_idx_q     <= rx_idx_d;
			rx_chk_q     <= rx_chk_d;
		end
	end

	// burst register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (advance && (n_d != '0)) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && m_tready) begin
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	// burst register payload
	always_ff @(posedge clk) begin
		if (advance && (n_d != '0)) begin
			bytes_s2    <= bytes_d;
			last_idx_s2 <= RES_IDX_W'(n_d - (RES_IDX_W+1)'(1));
			kind_s2     <= kind_d;
			ok_s2       <= ok_d;
			bad_s2      <= bad_d;
		end
	end

	// master side
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, bad_s2, ok_s2, bytes_s2[idx_q]};
	assign m_tuser  = kind_s2;
	assign m_tlast  = (idx_q == last_idx_s2);

endmodule

`default_nettype wire

[dv/sxf_frame_checker.sv]
// checker for the stx/etx framer and deframer core: watches both stream sides,
// predicts the results of every accepted item and compares them in order
// depends on sxf_pkg
module sxf_frame_checker
	import sxf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] payload_count
	input  wire logic        s_tuser,   // [0] op
	input  wire logic        s_tlast,   // last_payload
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,   // [7:0] out_byte, [8] checksum_ok, [9] bad_length
	input  wire logic [1:0]  m_tuser,   // [1:0] kind
	input  wire logic        m_tlast,   // last
	output int               n_fail,
	output int               n_pending,
	output int               n_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       last;
		logic       checksum_ok;
		logic       bad_length;
	} line_res_t;

	// framer state
	logic       toggle;
	logic       tx_open;
	logic [7:0] tx_xor;

	// deframer state
	rx_phase_t  rx_phase;
	logic [7:0] rx_len;
	logic [7:0] rx_idx;
	logic [7:0] rx_xor;

	line_res_t  due_results[$];
	line_res_t  head;

	function automatic void push_result(kind_t k, logic [7:0] b, logic ok, logic bad);
		line_res_t r;
		r.kind        = k;
		r.out_byte    = b;
		r.last        = 1'b0;
		r.checksum_ok = ok;
		r.bad_length  = bad;
		due_results.insert(due_results.size(), r);
	endfunction

	// next framer/deframer state and the results one item causes
	function automatic void predict_results(op_t op, logic [7:0] b, logic [7:0] cnt,
			logic lastp);
		int         depth_in;
		logic [7:0] sent;
		logic [7:0] len_b;
		depth_in = due_results.size();
		sent     = b;
		if (op == OP_TX_PAYLOAD) begin
			// frame opens with stx and the length byte, toggle goes into the first byte
			if (!tx_open) begin
				len_b = cnt + LEN_OVERHEAD;
				push_result(KIND_TX_BYTE, STX_BYTE, 1'b0, 1'b0);
				push_result(KIND_TX_BYTE, len_b, 1'b0, 1'b0);
				tx_xor  = len_b;
				sent    = b | {7'd0, toggle};
				tx_open = 1'b1;
			end
			tx_xor ^= sent;
			push_result(KIND_TX_BYTE, sent, 1'b0, 1'b0);
			if (lastp) begin
				push_result(KIND_TX_BYTE, ETX_BYTE, 1'b0, 1'b0);
				push_result(KIND_TX_BYTE, tx_xor, 1'b0, 1'b0);
				tx_open = 1'b0;
				toggle  = ~toggle;
			end
		end else begin
			case (rx_phase)
				RX_LENGTH: begin
					rx_len = b;
					rx_xor = b;
					rx_idx = 8'd2;
					if (b < MIN_RX_LENGTH) begin
						push_result(KIND_RX_END, 8'h00, 1'b0, 1'b1);
						rx_phase = RX_HUNT;
					end else begin
						rx_phase = RX_BODY;
					end
				end
				RX_BODY: begin
					// payload, then the unchecked etx slot, then the checksum
					if ({1'b0, rx_idx} + 9'd2 < {1'b0, rx_len}) begin
						rx_xor ^= b;
						push_result(KIND_RX_PAYLOAD, b, 1'b0, 1'b0);
						rx_idx = rx_idx + 8'd1;
					end else if ({1'b0, rx_idx} + 9'd2 == {1'b0, rx_len}) begin
						rx_idx = rx_idx + 8'd1;
					end else begin
						push_result(KIND_RX_END, 8'h00, rx_xor == b, 1'b0);
						rx_phase = RX_HUNT;
					end
				end
				default: begin
					rx_phase = (b == STX_BYTE) ? RX_LENGTH : RX_HUNT;
				end
			endcase
		end
		// mark the final result of this item's run
		if (due_results.size() > depth_in)
			due_results[due_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			n_fail++;
		end
	endfunction

	// predict on input items, compare on output items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle    = 1'b0;
			tx_open   = 1'b0;
			tx_xor    = 8'h00;
			rx_phase  = RX_HUNT;
			rx_len    = 8'h00;
			rx_idx    = 8'h00;
			rx_xor    = 8'h00;
			n_fail    = 0;
			n_checked = 0;
			due_results.delete();
			n_pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_results(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tlast);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("unexpected item: tuser %0h tdata %0h tlast %0b",
						m_tuser, m_tdata, m_tlast);
					n_fail++;
				end else begin
					head = due_results.pop_front();
					check_field("kind", head.kind, m_tuser);
					check_field("out_byte", head.out_byte, m_tdata[7:0]);
					check_field("checksum_ok", head.checksum_ok, m_tdata[8]);
					check_field("bad_length", head.bad_length, m_tdata[9]);
					check_field("tdata pad", 0, m_tdata[15:10]);
					check_field("last", head.last, m_tlast);
					n_checked++;
				end
			end
			n_pending <= due_results.size();
		end
	end

endmodule

[dv/tb.sv]
// top of the stx/etx framer and deframer testbench: clock, reset, stimulus and verdict
// depends on sxf_pkg, the core and sxf_frame_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sxf_pkg::*;

	localparam int N_ITEMS      = 450;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] cnt;
		logic       lastp;
		logic       counted;
	} link_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = 16'h0000;   // [7:0] data_byte, [15:8] payload_count
	logic        s_tuser  = 1'b0;       // [0] op
	logic        s_tlast  = 1'b0;       // last_payload
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;               // [7:0] out_byte, [8] checksum_ok, [9] bad_length
	logic [1:0]  m_tuser;               // [1:0] kind
	logic        m_tlast;               // last

	int n_fail;
	int n_pending;
	int n_checked;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int n_items       = 0;
	int n_tx_frames   = 0;
	int n_rx_frames   = 0;

	stx_etx_xor_framer_deframer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sxf_frame_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.n_checked (n_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** stx_etx_xor_framer_deframer_core: FAILED **");
		$finish;
	end

	function automatic link_item_t tx_byte(logic [7:0] d, logic [7:0] cnt, logic lp);
		link_item_t it;
		it.op      = OP_TX_PAYLOAD;
		it.data    = d;
		it.cnt     = cnt;
		it.lastp   = lp;
		it.counted = 1'b1;
		return it;
	endfunction

	// unused fields of a line byte carry random values
	function automatic link_item_t rx_byte(logic [7:0] d, logic counted);
		link_item_t it;
		it.op      = OP_RX_LINE;
		it.data    = d;
		it.cnt     = 8'($urandom_range(255));
		it.lastp   = 1'($urandom_range(1));
		it.counted = counted;
		return it;
	endfunction

	task automatic send_item(input link_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.cnt, it.data};
		s_tuser  <= it.op;
		s_tlast  <= it.lastp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (it.counted)
			n_items++;
	endtask

	// hold the sender until every expected result is out, then let the core settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one transmit frame and/or one receive sequence, interleaved at random
	task automatic run_episode();
		link_item_t tx_q[$];
		link_item_t rx_q[$];
		int         sel;
		int         n;
		logic [7:0] cnt;
		logic [7:0] d;
		logic [7:0] xsum;
		sel = $urandom_range(99);
		if (sel < 60) begin
			n   = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
			cnt = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(n);
			for (int i = 0; i < n; i++)
				tx_q.insert(tx_q.size(), tx_byte(8'($urandom_range(255)),
					(i == 0) ? cnt : 8'($urandom_range(255)), i == n - 1));
			n_tx_frames++;
		end
		if (sel >= 35) begin
			sel = $urandom_range(99);
			if (sel < 5) begin
				// plain line noise, stx included by chance
				repeat ($urandom_range(4, 1))
					rx_q.insert(rx_q.size(), rx_byte(8'($urandom_range(255)), 1'b0));
			end else begin
				repeat ($urandom_range(2)) begin
					d = 8'($urandom_range(255));
					if (d == STX_BYTE)
						d = 8'hFD;
					rx_q.insert(rx_q.size(), rx_byte(d, 1'b0));
				end
				rx_q.insert(rx_q.size(), rx_byte(STX_BYTE, 1'b1));
				if (sel < 20) begin
					// short length byte
					rx_q.insert(rx_q.size(), rx_byte(8'($urandom_range(4)), 1'b1));
				end else begin
					n    = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
					xsum = 8'(n) + LEN_OVERHEAD;
					rx_q.insert(rx_q.size(), rx_byte(xsum, 1'b1));
					repeat (n) begin
						d = 8'($urandom_range(255));
						xsum ^= d;
						rx_q.insert(rx_q.size(), rx_byte(d, 1'b1));
					end
					rx_q.insert(rx_q.size(), rx_byte(($urandom_range(9) == 0) ?
						8'($urandom_range(255)) : ETX_BYTE, 1'b1));
					if ($urandom_range(4) == 0)
						xsum ^= 8'($urandom_range(255, 1));
					rx_q.insert(rx_q.size(), rx_byte(xsum, 1'b1));
					// truncated frame: the next bytes may land in its body
					if (sel >= 92) begin
						n = $urandom_range(rx_q.size() - 1, 1);
						while (rx_q.size() > n)
							rx_q.delete(rx_q.size() - 1);
					end
				end
				n_rx_frames++;
			end
		end
		while (tx_q.size() + rx_q.size() > 0) begin
			if (rx_q.size() == 0 || (tx_q.size() != 0 && $urandom_range(1) == 1))
				send_item(tx_q.pop_front());
			else
				send_item(rx_q.pop_front());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 14;
		sink_idle_pct <= 83;

		// single-byte frames at the data extremes, length byte wrapping
		send_item(tx_byte(8'hFF, 8'd1, 1'b1));
		send_item(tx_byte(8'h00, 8'hFF, 1'b1));
		// count disagrees with bytes sent
		send_item(tx_byte(8'h80, 8'd251, 1'b0));
		send_item(tx_byte(8'h7F, 8'd0, 1'b1));
		// noise before stx, then two short lengths
		send_item(rx_byte(8'h55, 1'b1));
		send_item(rx_byte(8'hFF, 1'b1));
		send_item(rx_byte(STX_BYTE, 1'b1));
		send_item(rx_byte(8'h00, 1'b1));
		send_item(rx_byte(STX_BYTE, 1'b1));
		send_item(rx_byte(8'h04, 1'b1));
		// smallest good frame, correct checksum
		send_item(rx_byte(STX_BYTE, 1'b1));
		send_item(rx_byte(8'h05, 1'b1));
		send_item(rx_byte(8'hAA, 1'b1));
		send_item(rx_byte(ETX_BYTE, 1'b1));
		send_item(rx_byte(8'hAF, 1'b1));
		// transmit and receive interleaved, bad checksum
		send_item(rx_byte(STX_BYTE, 1'b1));
		send_item(tx_byte(8'h12, 8'd2, 1'b0));
		send_item(rx_byte(8'h06, 1'b1));
		send_item(rx_byte(8'h01, 1'b1));
		send_item(tx_byte(8'h34, 8'd9, 1'b1));
		send_item(rx_byte(8'hFE, 1'b1));
		send_item(rx_byte(ETX_BYTE, 1'b1));
		send_item(rx_byte(8'hF8, 1'b1));

		while (n_items < N_ITEMS / 3)
			run_episode();
		wait_drained();

		src_idle_pct = 83;
		sink_idle_pct <= 14;
		while (n_items < 2 * N_ITEMS / 3)
			run_episode();
		wait_drained();

		src_idle_pct = 0;
		sink_idle_pct <= 0;
		while (n_items < N_ITEMS)
			run_episode();
		wait_drained();

		$display("run: %0d items sent, %0d results checked", n_items, n_checked);
		$display("random part: %0d transmit frames, %0d receive sequences (short, bad, cut)",
			n_tx_frames, n_rx_frames);
		if (n_fail == 0)
			$display("** stx_etx_xor_framer_deframer_core: PASSED **");
		else
			$display("** stx_etx_xor_framer_deframer_core: FAILED **");
		$finish;
	end

endmodule
